// ===== rtl/itda_pkg.sv =====
// ============================================================================
// itda_pkg: shared types and constants for the signed integer to ASCII core
// Holds field widths, character codes, the cell control group and the
// controller state type.
// ============================================================================
`default_nettype none

package itda_pkg;

  localparam int VALUE_W    = 32;
  localparam int MAG_W      = VALUE_W;
  localparam int CNT_W      = $clog2(MAG_W);
  localparam int NUM_DIGITS = 10;
  localparam int DCNT_W     = $clog2(NUM_DIGITS + 1);
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;

  localparam logic [CHAR_W-1:0]  CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0]  CH_MINUS = 8'd45;
  localparam logic [DIGIT_W-1:0] BCD_FIVE = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ  = 4'd3;

  typedef struct packed {
    logic clr;
    logic bit_shift;
    logic dig_shift;
  } cell_ctrl_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SKIP = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/itda_in_if.sv =====
// ============================================================================
// itda_in_if: input channel of the signed integer to ASCII core
// Carries one signed 32-bit integer per beat with a valid/ready handshake.
// ============================================================================
`default_nettype none

interface itda_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [itda_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/itda_out_if.sv =====
// ============================================================================
// itda_out_if: output channel of the signed integer to ASCII core
// Carries one ASCII character and its last-character mark per beat.
// ============================================================================
`default_nettype none

interface itda_out_if;
  logic                        valid;
  logic                        ready;
  logic [itda_pkg::CHAR_W-1:0] char_code;
  logic                        is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink (input valid, input char_code, input is_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii_core.sv =====
// ============================================================================
// signed_int_to_decimal_ascii_core: signed 32-bit integer to decimal ASCII
// Converts one integer at a time and emits its text one character per beat.
// ============================================================================
// One integer is taken per conversion. Its 32-bit magnitude is shifted bit by
// bit into a chain of ten BCD cells, leading zeros are then shifted off the
// top of the chain one digit per cycle, and the characters follow one per
// output beat, a minus sign first for a negative value. The last character
// of each number carries is_last, and no terminator is sent. A new integer is
// accepted only after the last character of the previous one has been taken.
`default_nettype none

module signed_int_to_decimal_ascii_core (
  input  wire logic   clk,
  input  wire logic   rst,
  itda_in_if.sink     din,
  itda_out_if.source  dout
);
  import itda_pkg::*;

  state_t             state;
  state_t             state_next;
  logic               neg;
  logic [MAG_W-1:0]   mag;
  logic [CNT_W-1:0]   bit_cnt;
  logic [DCNT_W-1:0]  ndig;
  cell_ctrl_t         cc;
  logic [DIGIT_W-1:0] top_digit;
  logic [MAG_W-1:0]   raw;

  assign raw = din.value;

  itda_chain u_chain (
    .clk       (clk),
    .ctrl      (cc),
    .bit_in    (mag[MAG_W-1]),
    .top_digit (top_digit)
  );

  always_comb begin
    state_next     = state;
    cc             = '0;
    din.ready      = (state == ST_IDLE);
    dout.valid     = (state == ST_SIGN) || (state == ST_EMIT);
    dout.char_code = (state == ST_SIGN) ? CH_MINUS
                                        : CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
    dout.is_last   = (state == ST_EMIT) && (ndig == DCNT_W'(1));
    case (state)
      ST_IDLE: begin
        if (din.valid) begin
          cc.clr     = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cc.bit_shift = 1'b1;
        if (bit_cnt == CNT_W'(MAG_W - 1)) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if ((top_digit == '0) && (ndig != DCNT_W'(1))) begin
          cc.dig_shift = 1'b1;
        end else begin
          state_next = neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (dout.ready) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (dout.ready) begin
          cc.dig_shift = 1'b1;
          if (ndig == DCNT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && din.valid) begin
      neg     <= raw[MAG_W-1];
      mag     <= raw[MAG_W-1] ? (~raw + 1'b1) : raw;
      bit_cnt <= '0;
      ndig    <= DCNT_W'(NUM_DIGITS);
    end else if (state == ST_CONV) begin
      mag     <= {mag[MAG_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + 1'b1;
    end else if (cc.dig_shift) begin
      ndig <= ndig - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/itda_bcd_cell.sv =====
// ============================================================================
// itda_bcd_cell: one decimal digit of the conversion chain
// Holds a BCD digit. In a bit step it applies the add-three correction and
// shifts in one bit from its lower neighbor; in a digit step it takes the
// lower neighbor's digit whole.
// ============================================================================
`default_nettype none

module itda_bcd_cell (
  input  wire logic                         clk,
  input  wire itda_pkg::cell_ctrl_t         ctrl,
  input  wire logic                         bit_in,
  input  wire logic [itda_pkg::DIGIT_W-1:0] dig_in,
  output logic      [itda_pkg::DIGIT_W-1:0] digit,
  output logic                              bit_out
);
  import itda_pkg::*;

  logic [DIGIT_W-1:0] adj;

  assign adj     = (digit >= BCD_FIVE) ? digit + BCD_ADJ : digit;
  assign bit_out = adj[DIGIT_W-1];

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      digit <= '0;
    end else if (ctrl.bit_shift) begin
      digit <= {adj[DIGIT_W-2:0], bit_in};
    end else if (ctrl.dig_shift) begin
      digit <= dig_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/itda_chain.sv =====
// ============================================================================
// itda_chain: row of BCD cells
// Cell zero is the least significant digit. Bits enter at cell zero and
// ripple upward; during output the digits move up one cell per step so that
// the top cell always shows the next character.
// ============================================================================
`default_nettype none

module itda_chain (
  input  wire logic                         clk,
  input  wire itda_pkg::cell_ctrl_t         ctrl,
  input  wire logic                         bit_in,
  output logic      [itda_pkg::DIGIT_W-1:0] top_digit
);
  import itda_pkg::*;

  logic [DIGIT_W-1:0] digs  [NUM_DIGITS];
  logic               carry [NUM_DIGITS-1];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic               c_in;
    logic [DIGIT_W-1:0] d_in;

    if (i == 0) begin : g_low
      assign c_in = bit_in;
      assign d_in = '0;
    end else begin : g_mid
      assign c_in = carry[i-1];
      assign d_in = digs[i-1];
    end

    if (i == NUM_DIGITS - 1) begin : g_top
      itda_bcd_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .bit_in  (c_in),
        .dig_in  (d_in),
        .digit   (digs[i]),
        .bit_out ()
      );
    end else begin : g_body
      itda_bcd_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .bit_in  (c_in),
        .dig_in  (d_in),
        .digit   (digs[i]),
        .bit_out (carry[i])
      );
    end
  end

  assign top_digit = digs[NUM_DIGITS-1];

endmodule

`default_nettype wire

// ===== rtl/itda_checker.sv =====
// ============================================================================
// itda_checker: port-level checks for the signed integer to ASCII core
// Watches both channels and flags ordering and character slips.
// ============================================================================
`default_nettype none

module itda_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [itda_pkg::CHAR_W-1:0] char_code,
  input wire logic                        is_last
);
  import itda_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(is_last))
    else $error("stalled output beat changed");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while characters are pending");

  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid)
    else $error("output beat right after an input beat");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (char_code == CH_MINUS) |-> !is_last)
    else $error("minus sign marked as last character");

  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code == CH_MINUS) ||
                  ((char_code >= CH_ZERO) && (char_code <= CH_ZERO + 8'd9)))
    else $error("character outside sign and digits");

endmodule

bind signed_int_to_decimal_ascii_core itda_checker u_itda_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (din.valid),
  .in_ready  (din.ready),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .char_code (dout.char_code),
  .is_last   (dout.is_last)
);

`default_nettype wire
